// ===== rtl/gfa_pkg.sv =====
`timescale 1ns / 1ps

package gfa_pkg;

  localparam int NL         = 5;
  localparam int IN_W       = 54;
  localparam int OUT_W      = 55;
  localparam int LIMB_W     = 51;
  localparam int PIPE_DEPTH = 7;

  // partial product split: f limb 27+27, g (or 19g) limb 30+29
  localparam int FL_W  = 27;
  localparam int GL_W  = 30;
  localparam int GV_W  = 59;
  localparam int PP_W  = 57;
  localparam int PR_W  = 113;
  localparam int COL_W = 116;

  localparam logic [63:0] LIMB_MASK = 64'h7ffffffffffff;
  localparam logic [63:0] TWO_P0    = 64'hfffffffffffda;
  localparam logic [63:0] TWO_PI    = 64'hffffffffffffe;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_NEG = 2'd3
  } op_t;

  typedef logic [IN_W-1:0]  limb_in_t;
  typedef logic [OUT_W-1:0] limb_out_t;

  typedef logic [NL-1:0][63:0]              w5_t;
  typedef logic [NL-1:0][OUT_W-1:0]         r5_t;
  typedef logic [NL-1:0][NL-1:0][3:0][PP_W-1:0] pp_t;
  typedef logic [NL-1:0][COL_W-1:0]         col_t;
  typedef logic [PIPE_DEPTH:1]              stage_en_t;

  typedef struct packed {
    op_t      opcode;
    limb_in_t f_limb0;
    limb_in_t f_limb1;
    limb_in_t f_limb2;
    limb_in_t f_limb3;
    limb_in_t f_limb4;
    limb_in_t g_limb0;
    limb_in_t g_limb1;
    limb_in_t g_limb2;
    limb_in_t g_limb3;
    limb_in_t g_limb4;
  } gfa_in_t;

  typedef struct packed {
    limb_out_t r_limb0;
    limb_out_t r_limb1;
    limb_out_t r_limb2;
    limb_out_t r_limb3;
    limb_out_t r_limb4;
  } gfa_out_t;

  function automatic logic [63:0] two_p(input int i);
    return (i == 0) ? TWO_P0 : TWO_PI;
  endfunction

  // one weak carry pass with the top carry folded back times 19
  function automatic w5_t weak_carry(input w5_t v);
    w5_t         r;
    logic [63:0] c;
    c = '0;
    for (int i = 0; i < NL; i++) begin
      r[i] = v[i] + c;
      c    = r[i] >> LIMB_W;
      r[i] = r[i] & LIMB_MASK;
    end
    r[0] = r[0] + c * 64'd19;
    return r;
  endfunction

endpackage

// ===== rtl/gf25519_field_alu_core.sv =====
`timescale 1ns / 1ps

// Field ALU for GF(2^255-19), radix 2^51, five limbs per element. Opcodes: add,
// subtract (f + 2p - g), multiply, negate (2p - f after two weak carries).
// Results come out weakly reduced. The pipeline is seven register stages deep:
// partial products, product merge, column sums, three carry-chain stages and
// the output register. One beat is accepted every cycle unless the output stalls
// with every stage full. A stalled output holds the pipeline stage by stage, and
// empty stages keep filling while it waits.
module gf25519_field_alu_core import gfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  gfa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output gfa_out_t out_data
);

  stage_en_t v_r, v_nxt, en;
  pp_t       pp;
  col_t      col;
  r5_t       mul_res, lin_res, sel_res;
  op_t       lin_op;
  gfa_out_t  out_data_r;

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en[PIPE_DEPTH] = !v_r[PIPE_DEPTH] || out_ready;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[1] = en[1] ? in_valid : v_r[1];
    for (int k = 2; k <= PIPE_DEPTH; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  gfa_ppgen u_ppgen (
    .clk     (clk),
    .en      (en[1]),
    .in_data (in_data),
    .pp_r    (pp)
  );

  gfa_colsum u_colsum (
    .clk     (clk),
    .en_prod (en[2]),
    .en_col  (en[3]),
    .pp      (pp),
    .col_r   (col)
  );

  gfa_carry u_carry (
    .clk  (clk),
    .en_a (en[4]),
    .en_b (en[5]),
    .en_c (en[6]),
    .col  (col),
    .res  (mul_res)
  );

  gfa_lin u_lin (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .op_out  (lin_op),
    .res_out (lin_res)
  );

  // pick multiply or linear result into the output register
  assign sel_res = (lin_op == OP_MUL) ? mul_res : lin_res;

  always_ff @(posedge clk) begin
    if (en[PIPE_DEPTH]) begin
      out_data_r.r_limb0 <= sel_res[0];
      out_data_r.r_limb1 <= sel_res[1];
      out_data_r.r_limb2 <= sel_res[2];
      out_data_r.r_limb3 <= sel_res[3];
      out_data_r.r_limb4 <= sel_res[4];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[PIPE_DEPTH];
  assign out_data  = out_data_r;

endmodule

// ===== rtl/gfa_ppgen.sv =====
`timescale 1ns / 1ps

module gfa_ppgen import gfa_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  gfa_in_t in_data,
  output pp_t     pp_r
);

  pp_t pp_nxt;
  logic [NL-1:0][IN_W-1:0] f;
  logic [NL-1:0][IN_W-1:0] g;

  assign f = {in_data.f_limb4, in_data.f_limb3, in_data.f_limb2,
              in_data.f_limb1, in_data.f_limb0};
  assign g = {in_data.g_limb4, in_data.g_limb3, in_data.g_limb2,
              in_data.g_limb1, in_data.g_limb0};

  // form four partial products per schoolbook term, wrapped terms use 19g
  always_comb begin
    logic [GV_W-1:0] gv;
    logic [FL_W-1:0] fl;
    logic [FL_W-1:0] fh;
    logic [GL_W-1:0] gl;
    logic [GV_W-GL_W-1:0] gh;
    int gi;
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        gi = (i >= j) ? (i - j) : (NL + i - j);
        if (i >= j) begin
          gv = GV_W'(g[gi]);
        end else begin
          gv = (GV_W'(g[gi]) << 4) + (GV_W'(g[gi]) << 1) + GV_W'(g[gi]);
        end
        fl = f[j][FL_W-1:0];
        fh = f[j][IN_W-1:FL_W];
        gl = gv[GL_W-1:0];
        gh = gv[GV_W-1:GL_W];
        pp_nxt[i][j][0] = PP_W'(fl) * PP_W'(gl);
        pp_nxt[i][j][1] = PP_W'(fl) * PP_W'(gh);
        pp_nxt[i][j][2] = PP_W'(fh) * PP_W'(gl);
        pp_nxt[i][j][3] = PP_W'(fh) * PP_W'(gh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
    end
  end

endmodule

// ===== rtl/gfa_colsum.sv =====
`timescale 1ns / 1ps

module gfa_colsum import gfa_pkg::*; (
  input  logic clk,
  input  logic en_prod,
  input  logic en_col,
  input  pp_t  pp,
  output col_t col_r
);

  logic [NL-1:0][NL-1:0][PR_W-1:0] prod_r;
  logic [NL-1:0][NL-1:0][PR_W-1:0] prod_nxt;
  col_t col_nxt;

  // merge partial products into full terms
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        prod_nxt[i][j] = PR_W'(pp[i][j][0])
                       + (PR_W'(pp[i][j][1]) << GL_W)
                       + (PR_W'(pp[i][j][2]) << FL_W)
                       + (PR_W'(pp[i][j][3]) << (FL_W + GL_W));
      end
    end
  end

  // sum each column
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      col_nxt[i] = '0;
      for (int j = 0; j < NL; j++) begin
        col_nxt[i] = col_nxt[i] + COL_W'(prod_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod_r <= prod_nxt;
    end
    if (en_col) begin
      col_r <= col_nxt;
    end
  end

endmodule

// ===== rtl/gfa_carry.sv =====
`timescale 1ns / 1ps

module gfa_carry import gfa_pkg::*; (
  input  logic clk,
  input  logic en_a,
  input  logic en_b,
  input  logic en_c,
  input  col_t col,
  output r5_t  res
);

  logic [LIMB_W-1:0] h0_a_r, h1_a_r, h0_b_r, h1_b_r, h2_b_r, h3_b_r;
  logic [LIMB_W-1:0] h1_c_r, h2_c_r, h3_c_r, h4_c_r;
  logic [63:0]       c_a_r, c_b_r, h0_c_r;
  logic [COL_W-1:0]  col2_a_r, col3_a_r, col4_a_r, col4_b_r;

  logic [COL_W:0]    a0, a1, a2, a3, a4;
  logic [63:0]       c0, c2, c4;
  logic [63:0]       h1_fin;

  // first pair of carry steps
  assign a0 = {1'b0, col[0]};
  assign c0 = a0[LIMB_W+63:LIMB_W];
  assign a1 = {1'b0, col[1]} + (COL_W+1)'(c0);

  // second pair
  assign a2 = {1'b0, col2_a_r} + (COL_W+1)'(c_a_r);
  assign c2 = a2[LIMB_W+63:LIMB_W];
  assign a3 = {1'b0, col3_a_r} + (COL_W+1)'(c2);

  // last limb, carry out folds into limb 0
  assign a4 = {1'b0, col4_b_r} + (COL_W+1)'(c_b_r);
  assign c4 = a4[LIMB_W+63:LIMB_W];

  always_ff @(posedge clk) begin
    if (en_a) begin
      h0_a_r   <= a0[LIMB_W-1:0];
      h1_a_r   <= a1[LIMB_W-1:0];
      c_a_r    <= a1[LIMB_W+63:LIMB_W];
      col2_a_r <= col[2];
      col3_a_r <= col[3];
      col4_a_r <= col[4];
    end
    if (en_b) begin
      h0_b_r   <= h0_a_r;
      h1_b_r   <= h1_a_r;
      h2_b_r   <= a2[LIMB_W-1:0];
      h3_b_r   <= a3[LIMB_W-1:0];
      c_b_r    <= a3[LIMB_W+63:LIMB_W];
      col4_b_r <= col4_a_r;
    end
    if (en_c) begin
      h0_c_r <= 64'(h0_b_r) + c4 * 64'd19;
      h1_c_r <= h1_b_r;
      h2_c_r <= h2_b_r;
      h3_c_r <= h3_b_r;
      h4_c_r <= a4[LIMB_W-1:0];
    end
  end

  // push the limb 0 overflow into limb 1
  assign h1_fin = 64'(h1_c_r) + (h0_c_r >> LIMB_W);
  assign res[0] = OUT_W'(h0_c_r & LIMB_MASK);
  assign res[1] = h1_fin[OUT_W-1:0];
  assign res[2] = OUT_W'(h2_c_r);
  assign res[3] = OUT_W'(h3_c_r);
  assign res[4] = OUT_W'(h4_c_r);

endmodule

// ===== rtl/gfa_lin.sv =====
`timescale 1ns / 1ps

module gfa_lin import gfa_pkg::*; (
  input  logic      clk,
  input  stage_en_t en,
  input  gfa_in_t   in_data,
  output op_t       op_out,
  output r5_t       res_out
);

  localparam int LAST = PIPE_DEPTH - 1;

  op_t op_r  [1:LAST];
  r5_t res_r [1:LAST];
  r5_t res1_nxt, res2_nxt, res3_nxt;
  w5_t f, g, wc1, wc2;

  assign f = {64'(in_data.f_limb4), 64'(in_data.f_limb3), 64'(in_data.f_limb2),
              64'(in_data.f_limb1), 64'(in_data.f_limb0)};
  assign g = {64'(in_data.g_limb4), 64'(in_data.g_limb3), 64'(in_data.g_limb2),
              64'(in_data.g_limb1), 64'(in_data.g_limb0)};

  // add, subtract, or first weak carry of negate
  assign wc1 = weak_carry(f);
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      case (in_data.opcode)
        OP_ADD:  res1_nxt[i] = OUT_W'(f[i] + g[i]);
        OP_SUB:  res1_nxt[i] = OUT_W'(f[i] + two_p(i) - g[i]);
        OP_NEG:  res1_nxt[i] = OUT_W'(wc1[i]);
        default: res1_nxt[i] = '0;
      endcase
    end
  end

  // second weak carry of negate
  always_comb begin
    w5_t v;
    for (int i = 0; i < NL; i++) begin
      v[i] = 64'(res_r[1][i]);
    end
    wc2 = weak_carry(v);
    for (int i = 0; i < NL; i++) begin
      res2_nxt[i] = (op_r[1] == OP_NEG) ? OUT_W'(wc2[i]) : res_r[1][i];
    end
  end

  // negate: 2p minus the carried value
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      res3_nxt[i] = (op_r[2] == OP_NEG) ? OUT_W'(two_p(i)) - res_r[2][i] : res_r[2][i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op_r[1]  <= in_data.opcode;
      res_r[1] <= res1_nxt;
    end
    if (en[2]) begin
      op_r[2]  <= op_r[1];
      res_r[2] <= res2_nxt;
    end
    if (en[3]) begin
      op_r[3]  <= op_r[2];
      res_r[3] <= res3_nxt;
    end
    // hold alongside the multiply carry chain
    for (int k = 4; k <= LAST; k++) begin
      if (en[k]) begin
        op_r[k]  <= op_r[k-1];
        res_r[k] <= res_r[k-1];
      end
    end
  end

  assign op_out  = op_r[LAST];
  assign res_out = res_r[LAST];

endmodule
